FILE: rtl/core/sitp_pkg.sv
// package: phase and base codes, character classes and digit decoding for the parser
`timescale 1ns / 1ps

package sitp_pkg;

	localparam int unsigned ValueW = 32;
	localparam int unsigned TailW  = 16;
	localparam int unsigned MaxString = 65535;
	localparam logic [TailW-1:0] TailLimit =
		(MaxString < 65535) ? TailW'(MaxString) : TailW'(65535);

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChOne   = 8'h31;
	localparam logic [7:0] ChSeven = 8'h37;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowF  = 8'h66;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpF   = 8'h46;
	localparam logic [7:0] ChLowX  = 8'h78;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] LowAOff = 8'h57;
	localparam logic [7:0] UpAOff  = 8'h37;

	typedef enum logic [2:0] {
		PH_DONE   = 3'd0,
		PH_SPACE  = 3'd1,
		PH_PLUS   = 3'd2,
		PH_MINUS  = 3'd3,
		PH_DIGITS = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		BASE_2  = 2'd0,
		BASE_8  = 2'd1,
		BASE_10 = 2'd2,
		BASE_16 = 2'd3
	} base_t;

	typedef enum logic [2:0] {
		SEL_DEFAULT = 3'd0,
		SEL_TWO     = 3'd1,
		SEL_EIGHT   = 3'd2,
		SEL_TEN     = 3'd3,
		SEL_SIXTEEN = 3'd4
	} radix_sel_t;

	function automatic base_t base_of(input logic [2:0] sel);
		base_t b;
		unique case (sel)
			SEL_TWO:     b = BASE_2;
			SEL_EIGHT:   b = BASE_8;
			SEL_SIXTEEN: b = BASE_16;
			default:     b = BASE_10;
		endcase
		return b;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h09) || (c == 8'h0a) || (c == 8'h0b) || (c == 8'h0c) ||
			(c == 8'h0d) || (c == 8'h20);
	endfunction

	function automatic logic is_digit(input logic [7:0] c, input base_t b);
		logic ok;
		unique case (b)
			BASE_2:  ok = (c >= ChZero) && (c <= ChOne);
			BASE_8:  ok = (c >= ChZero) && (c <= ChSeven);
			BASE_16: ok = ((c >= ChZero) && (c <= ChNine)) ||
				((c >= ChLowA) && (c <= ChLowF)) || ((c >= ChUpA) && (c <= ChUpF));
			default: ok = (c >= ChZero) && (c <= ChNine);
		endcase
		return ok;
	endfunction

	function automatic logic [3:0] digit_val(input logic [7:0] c);
		logic [7:0] d;
		if (c >= ChLowA) begin
			d = c - LowAOff;
		end else if (c >= ChUpA) begin
			d = c - UpAOff;
		end else begin
			d = c - ChZero;
		end
		return d[3:0];
	endfunction

	function automatic logic [ValueW-1:0] mul_base(input logic [ValueW-1:0] a, input base_t b);
		logic [ValueW-1:0] r;
		unique case (b)
			BASE_2:  r = a << 1;
			BASE_8:  r = a << 3;
			BASE_16: r = a << 4;
			default: r = (a << 3) + (a << 1);
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/string_to_integer_parser_top.sv
// A word accepted goes to the input register, then to the result register when that one can advance.
// One word per cycle unless out_ready stalls; the state loop is one short multiply-add by shifts.
// While a finished result waits on out_ready the input register takes one more word, then stalls.
// Reset: arst_n, asynchronous, active low; parse ended and awaiting a start, no result pending.
// Words before the first start give value 0, tail_count 0, done_res 1.
// top level: character stream to integer parser
`timescale 1ns / 1ps

module string_to_integer_parser_top
	import sitp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               ch,
	input  logic                     start_req,
	input  logic [2:0]               radix_sel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ValueW-1:0] value,
	output logic [TailW-1:0]         tail_count,
	output logic                     done_res
);

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             start_s1;
	logic [2:0]       sel_s1;

	logic             valid_s2;
	logic [ValueW-1:0] value_s2;
	logic [TailW-1:0] tail_s2;
	logic             done_s2;

	phase_t           phase_q;
	logic             minus_q;
	logic [ValueW-1:0] acc_q;
	logic [TailW-1:0] pos_q;
	base_t            base_q;
	logic             fwz_q;

	phase_t           phase_e, phase_d;
	logic             minus_e, minus_d;
	logic [ValueW-1:0] acc_e, acc_d;
	logic [TailW-1:0] pos_e, pos_d, pos_inc;
	base_t            base_e, base_d;
	logic             fwz_e, fwz_d;
	logic             done_d;
	logic             adv;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1    <= ch;
			start_s1 <= start_req;
			sel_s1   <= radix_sel;
		end
	end

	// state as seen by the word: the fresh state after a start, else the held state
	always_comb begin
		if (start_s1) begin
			phase_e = PH_SPACE;
			minus_e = 1'b0;
			acc_e   = '0;
			pos_e   = '0;
			base_e  = base_of(sel_s1);
			fwz_e   = 1'b0;
		end else begin
			phase_e = phase_q;
			minus_e = minus_q;
			acc_e   = acc_q;
			pos_e   = pos_q;
			base_e  = base_q;
			fwz_e   = fwz_q;
		end
	end

	assign pos_inc = (pos_e < TailLimit) ? pos_e + TailW'(1) : pos_e;

	always_comb begin
		phase_d = phase_e;
		minus_d = minus_e;
		acc_d   = acc_e;
		pos_d   = pos_e;
		base_d  = base_e;
		fwz_d   = fwz_e;
		done_d  = 1'b0;
		if (phase_e == PH_DONE) begin
			done_d = 1'b1;
		end else begin
			fwz_d = 1'b0;
			priority if (fwz_e && ch_s1 == ChLowX) begin
				base_d  = BASE_16;
				phase_d = PH_SPACE;
				acc_d   = '0;
				minus_d = 1'b0;
				pos_d   = pos_inc;
			end else if (phase_e == PH_SPACE && is_blank(ch_s1)) begin
				pos_d = pos_inc;
			end else if (phase_e == PH_SPACE && ch_s1 == ChPlus) begin
				phase_d = PH_PLUS;
				pos_d   = pos_inc;
			end else if ((phase_e == PH_SPACE || phase_e == PH_PLUS) && ch_s1 == ChMinus) begin
				minus_d = 1'b1;
				phase_d = PH_MINUS;
				pos_d   = pos_inc;
			end else if (is_digit(ch_s1, base_e)) begin
				fwz_d   = (pos_e == '0) && (ch_s1 == ChZero);
				acc_d   = mul_base(acc_e, base_e) + ValueW'(digit_val(ch_s1));
				phase_d = PH_DIGITS;
				pos_d   = pos_inc;
			end else begin
				phase_d = PH_DONE;
				done_d  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DONE;
			minus_q  <= 1'b0;
			acc_q    <= '0;
			pos_q    <= '0;
			base_q   <= BASE_10;
			fwz_q    <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q <= phase_d;
				minus_q <= minus_d;
				acc_q   <= acc_d;
				pos_q   <= pos_d;
				base_q  <= base_d;
				fwz_q   <= fwz_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			value_s2 <= minus_d ? (ValueW'(0) - acc_d) : acc_d;
			tail_s2  <= pos_d;
			done_s2  <= done_d;
		end
	end

	assign out_valid  = valid_s2;
	assign value      = value_s2;
	assign tail_count = tail_s2;
	assign done_res   = done_s2;

`ifndef SYNTH
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with no result pending");

	a_taken_advances: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !done_s2 |-> tail_s2 != '0)
		else $error("taken word left tail at zero");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s1 && !start_s1 && phase_q == PH_DONE |=> done_s2 && tail_s2 == $past(pos_q))
		else $error("word after end changed result");
`endif

endmodule
